### rtl/core/psdes_pkg.sv
// Package with payload types, register map constants and reset values.
`default_nettype none

package psdes_pkg;

  localparam int unsigned NumRegs           = 8;
  localparam int unsigned CfgIdxW           = 3;
  localparam int unsigned TableDepth        = 4;
  localparam int unsigned RoundIdxW         = 2;
  localparam int unsigned RoundCountDefault = 4;

  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdCipher = 1'b1;

  localparam logic [31:0] RoundConstAReset [TableDepth] = '{
    32'd1682317244, 32'd880974089, 32'd3847169472, 32'd623303607
  };
  localparam logic [31:0] RoundConstBReset [TableDepth] = '{
    32'd632873013, 32'd487476637, 32'd3149672924, 32'd2808002168
  };

  localparam logic [31:0] BlockCounterReset = 32'd1;

  typedef struct packed {
    logic        command;
    logic [31:0] key_value;
    logic [31:0] counter_value;
    logic        new_buffer;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  result_byte;
    logic [31:0] counter_now;
  } out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } round_const_t;

endpackage

`default_nettype wire

### rtl/core/psdes_cfg.sv
// Round constant register file with write port and per-round selection.
`default_nettype none

module psdes_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [psdes_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [31:0]                     cfg_wdata_i,
  input  wire logic [psdes_pkg::RoundIdxW-1:0] round_i,
  output      psdes_pkg::round_const_t         round_const_o
);
  import psdes_pkg::*;

  logic [31:0] const_a_q [TableDepth];
  logic [31:0] const_b_q [TableDepth];
  logic [RoundIdxW-1:0] wr_slot;

  assign wr_slot = cfg_idx_i[RoundIdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) begin
        const_a_q[i] <= RoundConstAReset[i];
        const_b_q[i] <= RoundConstBReset[i];
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i[CfgIdxW-1]) begin
        const_b_q[wr_slot] <= cfg_wdata_i;
      end else begin
        const_a_q[wr_slot] <= cfg_wdata_i;
      end
    end
  end

  assign round_const_o.a = const_a_q[round_i];
  assign round_const_o.b = const_b_q[round_i];

endmodule

`default_nettype wire

### rtl/core/psdes_round.sv
// Shared pseudo-DES round unit: registered squares and cross product, then mixing.
`default_nettype none

module psdes_round (
  input  wire logic                    clk_i,
  input  wire logic                    mul_en_i,
  input  wire logic [31:0]             ctr_i,
  input  wire logic [31:0]             key_i,
  input  wire psdes_pkg::round_const_t round_const_i,
  output      logic [31:0]             result_o
);
  import psdes_pkg::*;

  logic [31:0] t_in;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [31:0] sq_lo_q;
  logic [31:0] sq_hi_q;
  logic [31:0] cross_q;
  logic [31:0] t_sum;
  logic [31:0] t_rot;

  assign t_in = ctr_i ^ round_const_i.a;
  assign hi   = {16'h0000, t_in[31:16]};
  assign lo   = {16'h0000, t_in[15:0]};

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      sq_lo_q <= lo * lo;
      sq_hi_q <= hi * hi;
      cross_q <= lo * hi;
    end
  end

  assign t_sum    = sq_lo_q + ~sq_hi_q;
  assign t_rot    = {t_sum[15:0], t_sum[31:16]};
  assign result_o = ((t_rot ^ round_const_i.b) + cross_q) ^ key_i;

endmodule

`default_nettype wire

### rtl/core/pseudo_des_keystream_cipher_unit.sv
// Top level: keystream cipher with sequencer around a shared hash round unit.
// A load transaction gives no result.
// A byte at group position zero runs a multiply and a mix step in each round through
// the single round unit, then the emit step; other bytes go straight to the emit step.
// One output register lets a new transaction be accepted while a result waits.
// Reset restores the round constants, clears key, keystream and position, counter to one.
`default_nettype none

module pseudo_des_keystream_cipher_unit #(
  parameter int unsigned ROUND_COUNT = psdes_pkg::RoundCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire psdes_pkg::in_t                in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      psdes_pkg::out_t               out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [psdes_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                   cfg_wdata_i
);
  import psdes_pkg::*;

  typedef enum logic [1:0] {StIdle, StMul, StMix, StEmit} state_e;

  localparam logic [RoundIdxW-1:0] LastRound = RoundIdxW'(ROUND_COUNT - 1);

  state_e               state_q, state_d;
  logic [31:0]          neg_key_q, neg_key_d;
  logic [31:0]          blk_ctr_q, blk_ctr_d;
  logic [1:0]           pos_q, pos_d;
  logic [7:0]           ks_q [4];
  logic                 ks_we;
  logic [31:0]          hash_k_q, hash_k_d;
  logic [31:0]          hash_c_q, hash_c_d;
  logic [RoundIdxW-1:0] round_q, round_d;
  logic [7:0]           data_q, data_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_data_q, out_data_d;

  round_const_t         round_const;
  logic [31:0]          round_res;
  logic                 in_accept;
  logic                 out_free;
  logic [1:0]           pos_eff;

  psdes_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .round_i       (round_q),
    .round_const_o (round_const)
  );

  psdes_round u_round (
    .clk_i         (clk_i),
    .mul_en_i      (state_q == StMul),
    .ctr_i         (hash_c_q),
    .key_i         (hash_k_q),
    .round_const_i (round_const),
    .result_o      (round_res)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign pos_eff     = in_data_i.new_buffer ? 2'd0 : pos_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    neg_key_d   = neg_key_q;
    blk_ctr_d   = blk_ctr_q;
    pos_d       = pos_q;
    hash_k_d    = hash_k_q;
    hash_c_d    = hash_c_q;
    round_d     = round_q;
    data_d      = data_q;
    ks_we       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (in_data_i.command == CmdLoad) begin
            neg_key_d = ~(in_data_i.key_value - 32'd1);
            blk_ctr_d = in_data_i.counter_value;
            pos_d     = 2'd0;
          end else begin
            data_d = in_data_i.data_byte;
            pos_d  = pos_eff;
            if (pos_eff == 2'd0) begin
              hash_k_d = neg_key_q;
              hash_c_d = blk_ctr_q;
              round_d  = '0;
              state_d  = StMul;
            end else begin
              state_d = StEmit;
            end
          end
        end
      end
      StMul: begin
        state_d = StMix;
      end
      StMix: begin
        hash_k_d = hash_c_q;
        hash_c_d = round_res;
        if (round_q == LastRound) begin
          ks_we     = 1'b1;
          blk_ctr_d = blk_ctr_q + 32'd1;
          state_d   = StEmit;
        end else begin
          round_d = round_q + RoundIdxW'(1);
          state_d = StMul;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.result_byte = data_q ^ ks_q[pos_q];
          out_data_d.counter_now = blk_ctr_q;
          pos_d                  = pos_q + 2'd1;
          state_d                = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      neg_key_q   <= '0;
      blk_ctr_q   <= BlockCounterReset;
      pos_q       <= '0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        ks_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      neg_key_q   <= neg_key_d;
      blk_ctr_q   <= blk_ctr_d;
      pos_q       <= pos_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
      if (ks_we) begin
        ks_q[3] <= round_res[7:0];
        ks_q[2] <= round_res[8:1];
        ks_q[1] <= round_res[9:2];
        ks_q[0] <= round_res[10:3];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hash_k_q   <= hash_k_d;
    hash_c_q   <= hash_c_d;
    data_q     <= data_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire
